// ===== src/lnbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lnbp_pkg
// Shared types and constants for the nine-bit word and pixel packer.
// ----------------------------------------------------------------------------
package lnbp_pkg;

   // Kind of request carried on the input channel.
   typedef enum logic [1:0] {
      REQ_CMD    = 2'd0,
      REQ_DATA   = 2'd1,
      REQ_PIXEL  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   // Mask that keeps the upper nibble of a colour channel.
   localparam logic [7:0] NIB_HI = 8'hF0;

   // Most words that a single request can give.
   localparam int unsigned MAX_WORDS = 3;

   // One nine-bit word on the serial link.
   typedef struct packed {
      logic       is_data;
      logic [7:0] byte_val;
   } word_type;

   // All words that one request gives, with their count.
   typedef struct packed {
      logic [1:0]                    count;
      word_type [MAX_WORDS-1:0]      words;
   } bundle_type;

endpackage

// ===== src/lnbp_pack.sv =====
// ----------------------------------------------------------------------------
// lnbp_pack
// Turns one registered request into its group of words and keeps the
// half-finished pixel pair between requests.
// ----------------------------------------------------------------------------
module lnbp_pack (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  lnbp_pkg::req_kind_type kind,
   input  logic [7:0]            byte_value,
   input  logic [7:0]            red_in,
   input  logic [7:0]            green_in,
   input  logic [7:0]            blue_in,
   output lnbp_pkg::bundle_type  bundle
);

   logic       odd_phase_ff, odd_phase_in;
   logic [7:0] held_rg_ff, held_rg_in;
   logic [3:0] held_blue_ff, held_blue_in;

   always_comb begin
      bundle       = '0;
      odd_phase_in = odd_phase_ff;
      held_rg_in   = held_rg_ff;
      held_blue_in = held_blue_ff;
      unique case (kind)
         lnbp_pkg::REQ_CMD: begin
            bundle.count             = 2'd1;
            bundle.words[0].is_data  = 1'b0;
            bundle.words[0].byte_val = byte_value;
         end
         lnbp_pkg::REQ_DATA: begin
            bundle.count             = 2'd1;
            bundle.words[0].is_data  = 1'b1;
            bundle.words[0].byte_val = byte_value;
         end
         lnbp_pkg::REQ_PIXEL: begin
            if (odd_phase_ff) begin
               // Second pixel of the pair completes three data words.
               bundle.count             = 2'd3;
               bundle.words[0].is_data  = 1'b1;
               bundle.words[0].byte_val = held_rg_ff;
               bundle.words[1].is_data  = 1'b1;
               bundle.words[1].byte_val = {held_blue_ff, red_in[7:4]};
               bundle.words[2].is_data  = 1'b1;
               bundle.words[2].byte_val = (green_in & lnbp_pkg::NIB_HI)
                                          | {4'd0, blue_in[7:4]};
               odd_phase_in             = 1'b0;
            end else begin
               // First pixel is only held.
               held_rg_in   = (red_in & lnbp_pkg::NIB_HI) | {4'd0, green_in[7:4]};
               held_blue_in = blue_in[7:4];
               odd_phase_in = 1'b1;
            end
         end
         default: begin
            bundle.count = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_phase_ff <= 1'b0;
         held_rg_ff   <= 8'd0;
         held_blue_ff <= 4'd0;
      end else if (take) begin
         odd_phase_ff <= odd_phase_in;
         held_rg_ff   <= held_rg_in;
         held_blue_ff <= held_blue_in;
      end
   end

endmodule

// ===== src/lnbp_emit.sv =====
// ----------------------------------------------------------------------------
// lnbp_emit
// Holds one group of words and sends them out one word per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module lnbp_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lnbp_pkg::bundle_type bundle_in,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_data,
   output logic [7:0]           rsp_word_byte,
   output logic                 rsp_last_word
);

   lnbp_pkg::bundle_type bundle_ff;
   logic                 valid_ff;
   logic [1:0]           idx_ff;
   lnbp_pkg::word_type   cur_word;
   logic                 at_last;

   assign cur_word      = bundle_ff.words[idx_ff];
   assign at_last       = (idx_ff == (bundle_ff.count - 2'd1));
   assign can_load      = !valid_ff || (rsp_ready && at_last);
   assign rsp_valid     = valid_ff;
   assign rsp_is_data   = cur_word.is_data;
   assign rsp_word_byte = cur_word.byte_val;
   assign rsp_last_word = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= (bundle_in.count != 2'd0);
         idx_ff   <= 2'd0;
      end else if (valid_ff && rsp_ready) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle_in;
      end
   end

endmodule

// ===== src/lcd_nine_bit_word_and_pixel_packer.sv =====
// ----------------------------------------------------------------------------
// lcd_nine_bit_word_and_pixel_packer
// Packs command bytes, data bytes and RGB pixels into nine-bit link words.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (valid/ready). A command byte gives one
// word with is_data low, a data byte one word with is_data high. Pixels are
// cut to four bits per channel and taken in pairs: the first pixel of a pair
// is held and gives nothing, the second gives three data words. Words leave
// on the rsp_ channel (valid/ready), one per cycle while rsp_ready is high,
// with last_word marking the final word of each request.
// An accepted request is held in the input register and moves to the word
// register once that register can take it; its first word is offered from
// there.
// Throughput is set by the word register, which sends one word a cycle while
// rsp_ready is high: command and data bytes flow at one per cycle, and a
// pixel pair gives three words.
// Requests that give no word (the first pixel of a pair, or the unused code)
// pass through the input register without waiting for the output side.
// Reset clears both registers' valid flags and the pair state, so the next
// pixel after reset is the first of a pair. When the receiver holds
// rsp_ready low the current word stays put, one further request waits in the
// input register and req_ready then drops until room appears.
// ----------------------------------------------------------------------------
module lcd_nine_bit_word_and_pixel_packer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_data,
   output logic [7:0] rsp_word_byte,
   output logic       rsp_last_word
);

   // Input register.
   logic                  in_valid_ff;
   lnbp_pkg::req_kind_type kind_ff;
   logic [7:0]            byte_ff;
   logic [7:0]            red_ff;
   logic [7:0]            green_ff;
   logic [7:0]            blue_ff;

   lnbp_pkg::bundle_type  bundle;
   logic                  can_load;
   logic                  load;
   logic                  take;

   // An item with no words may leave the input register whether or not the
   // word register is busy; otherwise it has to wait for room there.
   assign load      = in_valid_ff && can_load;
   assign take      = in_valid_ff && (can_load || (bundle.count == 2'd0));
   assign req_ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff  <= lnbp_pkg::req_kind_type'(req_type);
         byte_ff  <= req_byte_value;
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
      end
   end

   lnbp_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .kind       (kind_ff),
      .byte_value (byte_ff),
      .red_in     (red_ff),
      .green_in   (green_ff),
      .blue_in    (blue_ff),
      .bundle     (bundle)
   );

   lnbp_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .bundle_in     (bundle),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_data   (rsp_is_data),
      .rsp_word_byte (rsp_word_byte),
      .rsp_last_word (rsp_last_word)
   );

endmodule

// ===== tb/lcd_nine_bit_word_and_pixel_packer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nine_bit_word_and_pixel_packer_tb
// Self-checking bench for the nine-bit word and pixel packer.
// ----------------------------------------------------------------------------
// Command bytes, data bytes, pixels and the unused request code are offered
// on the request channel with random gaps. The words that leave on the
// response channel are compared, field by field and in order, with the words
// that a behavioural model of the packer predicts from the accepted requests.
// The response side stalls at random and once holds off for a long stretch,
// so that the packer fills up and pushes back on its input.
// ----------------------------------------------------------------------------
module lcd_nine_bit_word_and_pixel_packer_tb;

   // One expected word on the link, together with its end-of-request marker.
   typedef struct packed {
      logic       is_data;
      logic [7:0] payload;
      logic       last;
   } link_word_type;

   // Scoreboard: predicts the words that each accepted request gives and
   // compares the words that come out with the oldest prediction waiting.
   class link_word_scoreboard;
      bit             pixel_held;
      logic [7:0]     held_red_green;
      logic [3:0]     held_blue;
      link_word_type  expected_words[$];
      int unsigned    error_count;
      int unsigned    words_checked;
      int unsigned    kind_count[4];
      int unsigned    pairs_done;

      function void note_request(lnbp_pkg::req_kind_type kind, logic [7:0] byte_value,
                                 logic [7:0] red, logic [7:0] green,
                                 logic [7:0] blue);
         kind_count[kind]++;
         unique case (kind)
            lnbp_pkg::REQ_CMD: begin
               expected_words.push_back('{1'b0, byte_value, 1'b1});
            end
            lnbp_pkg::REQ_DATA: begin
               expected_words.push_back('{1'b1, byte_value, 1'b1});
            end
            lnbp_pkg::REQ_PIXEL: begin
               if (!pixel_held) begin
                  // First pixel of a pair: keep its nibbles, nothing goes out.
                  held_red_green = {red[7:4], green[7:4]};
                  held_blue      = blue[7:4];
                  pixel_held     = 1'b1;
               end else begin
                  pixel_held = 1'b0;
                  pairs_done++;
                  expected_words.push_back('{1'b1, held_red_green, 1'b0});
                  expected_words.push_back('{1'b1, {held_blue, red[7:4]}, 1'b0});
                  expected_words.push_back('{1'b1, {green[7:4], blue[7:4]}, 1'b1});
               end
            end
            default: begin
               // The unused code gives nothing and leaves a held pixel alone.
            end
         endcase
      endfunction

      function void check_word(logic is_data, logic [7:0] payload, logic last);
         link_word_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected word: is_data=%0b byte=%02h last=%0b",
                        $realtime, is_data, payload, last);
            return;
         end
         want = expected_words.pop_front();
         if (is_data !== want.is_data || payload !== want.payload ||
             last !== want.last) begin
            error_count++;
            if (error_count <= 10)
               $display({"%0t: word mismatch: expected is_data=%0b byte=%02h ",
                         "last=%0b, got is_data=%0b byte=%02h last=%0b"},
                        $realtime, want.is_data, want.payload, want.last,
                        is_data, payload, last);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = lnbp_pkg::REQ_CMD;
   logic [7:0] req_byte_value = 8'h00;
   logic [7:0] req_red_in = 8'h00;
   logic [7:0] req_green_in = 8'h00;
   logic [7:0] req_blue_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_data;
   logic [7:0] rsp_word_byte;
   logic       rsp_last_word;

   link_word_scoreboard link_words = new();

   // When set, neither side idles, so that back-to-back traffic is seen too.
   bit quiet_stretch = 1'b0;
   // Set by the stimulus to ask the response side for one long hold-off.
   bit long_hold_wanted = 1'b0;

   lcd_nine_bit_word_and_pixel_packer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_byte_value (req_byte_value),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_data    (rsp_is_data),
      .rsp_word_byte  (rsp_word_byte),
      .rsp_last_word  (rsp_last_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Idle length in cycles: mostly none, sometimes a few, now and then many.
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Offers one request after a random gap and waits until it is taken. The
   // valid line is only lowered when a gap is wanted, so a request that
   // follows straight on keeps valid high across the boundary.
   task automatic offer_request(input lnbp_pkg::req_kind_type kind,
                                input logic [7:0] byte_value,
                                input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue);
      int unsigned gap;
      gap = quiet_stretch ? 0 : idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_byte_value <= byte_value;
      req_red_in     <= red;
      req_green_in   <= green;
      req_blue_in    <= blue;
      do @(posedge clock); while (!req_ready);
      link_words.note_request(kind, byte_value, red, green, blue);
   endtask

   // A request with every field random; the unused fields carry noise too.
   task automatic offer_random(input lnbp_pkg::req_kind_type kind);
      offer_request(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Response side: samples the word at each edge, then decides whether it
   // is ready for the next cycle. The long hold-off is counted here.
   initial begin : response_side
      int unsigned stall_left;
      stall_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready)
            link_words.check_word(rsp_is_data, rsp_word_byte, rsp_last_word);
         if (long_hold_wanted && stall_left == 0) begin
            long_hold_wanted = 1'b0;
            stall_left = 80;
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (quiet_stretch) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = idle_cycles();
            if (stall_left != 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned            counted;
      int unsigned            roll;
      lnbp_pkg::req_kind_type kind;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: byte extremes, the unused code, pixel extremes and
      // the low nibbles that must be dropped.
      offer_request(lnbp_pkg::REQ_CMD,    8'h00, 8'hFF, 8'hFF, 8'hFF);
      offer_request(lnbp_pkg::REQ_CMD,    8'hFF, 8'h00, 8'h00, 8'h00);
      offer_request(lnbp_pkg::REQ_DATA,   8'h00, 8'hFF, 8'hFF, 8'hFF);
      offer_request(lnbp_pkg::REQ_DATA,   8'hFF, 8'h00, 8'h00, 8'h00);
      offer_request(lnbp_pkg::REQ_UNUSED, 8'hA5, 8'h5A, 8'hC3, 8'h3C);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'hFF, 8'h00, 8'h00, 8'h00);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h00, 8'h00, 8'h00, 8'h00);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h00, 8'hFF, 8'hFF, 8'hFF);
      // Only the low nibbles set: every packed nibble must come out zero.
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h00, 8'h0F, 8'h0F, 8'h0F);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'hFF, 8'h0F, 8'h0F, 8'h0F);
      // Distinct nibbles so that a swapped channel shows up.
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h00, 8'h1E, 8'h2D, 8'h3C);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h00, 8'h4B, 8'h5A, 8'h69);
      // Bytes and the unused code between the two pixels of a pair must not
      // disturb the held pixel.
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h55, 8'h80, 8'h90, 8'hA0);
      offer_request(lnbp_pkg::REQ_CMD,    8'h2C, 8'h00, 8'h00, 8'h00);
      offer_request(lnbp_pkg::REQ_DATA,   8'h81, 8'h00, 8'h00, 8'h00);
      offer_request(lnbp_pkg::REQ_UNUSED, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'hAA, 8'hB0, 8'hC0, 8'hD0);
      // Unused code before the first pixel of a pair.
      offer_request(lnbp_pkg::REQ_UNUSED, 8'hFF, 8'h00, 8'h00, 8'h00);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h00, 8'h70, 8'h80, 8'hF0);
      offer_request(lnbp_pkg::REQ_PIXEL,  8'h00, 8'h10, 8'h20, 8'h30);

      // Random part: mostly pixels, so that pairs form often, with command
      // and data bytes mixed in and a little of the unused code as noise.
      counted = 0;
      while (counted < 380) begin
         if (counted % 50 == 0)
            quiet_stretch = ($urandom_range(0, 3) == 0);
         if (counted == 150) begin
            // Hold the response side off while requests keep coming.
            quiet_stretch    = 1'b1;
            long_hold_wanted = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 55)
            kind = lnbp_pkg::REQ_PIXEL;
         else if (roll < 75)
            kind = lnbp_pkg::REQ_CMD;
         else if (roll < 93)
            kind = lnbp_pkg::REQ_DATA;
         else
            kind = lnbp_pkg::REQ_UNUSED;
         offer_random(kind);
         counted++;
      end
      req_valid <= 1'b0;
      quiet_stretch = 1'b0;

      // Let every predicted word arrive, then watch a while for strays.
      while (link_words.expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d commands, %0d data bytes, %0d pixels (%0d pairs), %0d unused.",
               link_words.kind_count[lnbp_pkg::REQ_CMD],
               link_words.kind_count[lnbp_pkg::REQ_DATA],
               link_words.kind_count[lnbp_pkg::REQ_PIXEL], link_words.pairs_done,
               link_words.kind_count[lnbp_pkg::REQ_UNUSED]);
      $display("Checked %0d words on the link, %0d mismatches.",
               link_words.words_checked, link_words.error_count);
      if (link_words.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Safety net against a hung handshake; far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("Timed out with %0d words still expected.",
               link_words.expected_words.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
